[rtl/prpz_pkg.sv]
// prpz_pkg: shared types, command codes and constants of the point rasterizer
// no dependencies
`default_nettype none
package prpz_pkg;

  typedef enum logic [1:0] {
    CMD_PLOT = 2'd0,
    CMD_READ = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [31:0]        glyph_in;
    logic [6:0]         cell_col;
    logic [4:0]         cell_row;
  } req_t;

  typedef struct packed {
    logic        cell_used;
    logic [31:0] cell_glyph;
    logic [2:0]  depth_class;
  } rsp_t;

  // projected cell from the transform pipeline
  typedef struct packed {
    logic               hit;
    logic signed [15:0] depth;
    logic [31:0]        glyph;
  } proj_t;

  localparam int unsigned AngleWrap  = 25723;
  localparam int unsigned PhaseMul   = 20861;
  localparam int unsigned PerspMul   = 3277;
  localparam logic [11:0] StepReset  = 12'd164;

  // quarter wave sine, Q1.14
  function automatic logic [14:0] qsin(input logic [5:0] k);
    logic [14:0] v;
    case (k)
      6'd0: v = 15'd0;       6'd1: v = 15'd804;     6'd2: v = 15'd1606;
      6'd3: v = 15'd2404;    6'd4: v = 15'd3196;    6'd5: v = 15'd3981;
      6'd6: v = 15'd4756;    6'd7: v = 15'd5520;    6'd8: v = 15'd6270;
      6'd9: v = 15'd7005;    6'd10: v = 15'd7723;   6'd11: v = 15'd8423;
      6'd12: v = 15'd9102;   6'd13: v = 15'd9760;   6'd14: v = 15'd10394;
      6'd15: v = 15'd11003;  6'd16: v = 15'd11585;  6'd17: v = 15'd12140;
      6'd18: v = 15'd12665;  6'd19: v = 15'd13160;  6'd20: v = 15'd13623;
      6'd21: v = 15'd14053;  6'd22: v = 15'd14449;  6'd23: v = 15'd14811;
      6'd24: v = 15'd15137;  6'd25: v = 15'd15426;  6'd26: v = 15'd15679;
      6'd27: v = 15'd15893;  6'd28: v = 15'd16069;  6'd29: v = 15'd16207;
      6'd30: v = 15'd16305;  6'd31: v = 15'd16364;  6'd32: v = 15'd16384;
      default: v = 15'd0;
    endcase
    return v;
  endfunction

  // interpolated sine of a 15 bit phase, Q1.14 signed
  function automatic logic signed [15:0] sine_q14(input logic [14:0] phase);
    logic [6:0]  idx;
    logic [7:0]  frac;
    logic [1:0]  quad;
    logic [4:0]  k;
    logic [14:0] a;
    logic [14:0] b;
    logic [23:0] acc;
    logic [15:0] v;
    idx  = phase[14:8];
    frac = phase[7:0];
    quad = idx[6:5];
    k    = idx[4:0];
    if (quad[0]) begin
      a = qsin(6'd32 - {1'b0, k});
      b = qsin(6'd31 - {1'b0, k});
    end else begin
      a = qsin({1'b0, k});
      b = qsin({1'b0, k} + 6'd1);
    end
    acc = 24'(a) * (24'd256 - 24'(frac)) + 24'(b) * 24'(frac) + 24'd128;
    v = {1'b0, acc[22:8]};
    return quad[1] ? -$signed(v) : $signed(v);
  endfunction

  function automatic logic [2:0] depth_class_of(input logic signed [15:0] z);
    logic [2:0] c;
    if (z > 16'sd204) c = 3'd0;
    else if (z > 16'sd128) c = 3'd1;
    else if (z > 16'sd51) c = 3'd2;
    else if (z > 16'sd0) c = 3'd3;
    else if (z > -16'sd52) c = 3'd4;
    else c = 3'd5;
    return c;
  endfunction

endpackage
`default_nettype wire

[rtl/point_rotate_project_zbuffer_top.sv]
// point_rotate_project_zbuffer_top: command decode, depth store read-modify-write
// plot: the four transform stages, then the store read-modify-write in the
// plot state; read: store read in the read state, response registered after it
// a new request is taken only in the idle state, so a plot or a read must finish
// and its response be taken before the next request; a tick leaves it idle
// reset: angle 0, step 164, clearing pass over every cell of the valid store
// during which no request is taken
`default_nettype none
module point_rotate_project_zbuffer_top #(
  parameter int unsigned SCREEN_WIDTH  = 80,
  parameter int unsigned SCREEN_HEIGHT = 24
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [11:0]           cfg_wdata_i,
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  input  wire prpz_pkg::req_t  req_i,
  output logic                 rsp_valid_o,
  input  wire                  rsp_ready_i,
  output prpz_pkg::rsp_t       rsp_o
);
  localparam int unsigned Cells = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned CellW = $clog2(Cells);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_XFORM, ST_PLOT, ST_READ, ST_RDATA, ST_RSP
  } state_e;

  state_e state_q;
  logic [2:0] cnt_q;
  logic [CellW-1:0] clr_q, addr_q;
  logic [11:0] step_q;
  logic [14:0] angle_q;
  prpz_pkg::proj_t proj, proj_q;
  logic [CellW-1:0] xcell;
  logic inrange_q;

  // stores: valid+depth and glyph
  logic st_we;
  logic [CellW-1:0] st_waddr, st_raddr;
  logic [16:0] vd_wdata, vd_rdata;
  logic [31:0] gl_rdata;
  logic gl_we;

  logic acc;
  assign req_ready_o = (state_q == ST_IDLE);
  assign acc = req_valid_i && req_ready_o;

  prpz_xform #(.ScreenWidth(SCREEN_WIDTH), .ScreenHeight(SCREEN_HEIGHT),
    .CellW(CellW)) u_xform (
    .clk_i, .start_i(acc), .req_i, .angle_i(angle_q),
    .proj_o(proj), .cell_o(xcell)
  );

  prpz_ram #(.Width(17), .Depth(Cells)) u_vd (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(vd_wdata),
    .raddr_i(st_raddr), .rdata_o(vd_rdata)
  );
  prpz_ram #(.Width(32), .Depth(Cells)) u_gl (
    .clk_i, .we_i(gl_we), .waddr_i(st_waddr), .wdata_i(proj_q.glyph),
    .raddr_i(st_raddr), .rdata_o(gl_rdata)
  );

  // store address and write control
  logic do_store;
  always_comb begin
    st_raddr = (state_q == ST_XFORM) ? xcell : addr_q;
    do_store = proj_q.hit && (!vd_rdata[16] ||
               ($signed(vd_rdata[15:0]) > proj_q.depth));
    st_we = 1'b0;
    gl_we = 1'b0;
    st_waddr = addr_q;
    vd_wdata = {1'b1, proj_q.depth};
    case (state_q)
      ST_CLEAR: begin
        st_we = 1'b1;
        st_waddr = clr_q;
        vd_wdata = '0;
      end
      ST_PLOT: begin
        st_we = do_store;
        gl_we = do_store;
      end
      ST_READ: begin
        st_we = inrange_q;
        vd_wdata = '0;
      end
      default: ;
    endcase
  end

  // sequencer and registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q <= '0;
      clr_q <= '0;
      addr_q <= '0;
      step_q <= prpz_pkg::StepReset;
      angle_q <= '0;
      rsp_valid_o <= 1'b0;
      inrange_q <= 1'b0;
    end else begin
      if (cfg_we_i) step_q <= cfg_wdata_i;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CellW'(Cells - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc) begin
            case (prpz_pkg::cmd_e'(req_i.command))
              prpz_pkg::CMD_PLOT: begin
                state_q <= ST_XFORM;
                cnt_q <= '0;
              end
              prpz_pkg::CMD_READ: begin
                inrange_q <= (32'(req_i.cell_col) < SCREEN_WIDTH) &&
                             (32'(req_i.cell_row) < SCREEN_HEIGHT);
                addr_q <= CellW'(32'(req_i.cell_row) * SCREEN_WIDTH +
                                 32'(req_i.cell_col));
                state_q <= ST_READ;
              end
              prpz_pkg::CMD_TICK: begin
                if (((16'(angle_q) + 16'(step_q)) & 16'h7FFF) >
                    16'(prpz_pkg::AngleWrap))
                  angle_q <= 15'((16'(angle_q) + 16'(step_q)) -
                                 16'(prpz_pkg::AngleWrap));
                else
                  angle_q <= angle_q + 15'(step_q);
              end
              default: ;
            endcase
          end
        end
        ST_XFORM: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 3'd3) begin
            proj_q <= proj;
            addr_q <= xcell;
            state_q <= ST_PLOT;
          end
        end
        ST_PLOT: state_q <= ST_IDLE;
        // read issued and cell cleared here, data arrives next cycle
        ST_READ: state_q <= ST_RDATA;
        ST_RDATA: begin
          rsp_valid_o <= 1'b1;
          rsp_o.cell_used <= inrange_q && vd_rdata[16];
          rsp_o.cell_glyph <= (inrange_q && vd_rdata[16]) ? gl_rdata : '0;
          rsp_o.depth_class <= (inrange_q && vd_rdata[16]) ?
                               prpz_pkg::depth_class_of(vd_rdata[15:0]) : 3'd0;
          state_q <= ST_RSP;
        end
        ST_RSP: begin
          if (rsp_ready_i) begin
            rsp_valid_o <= 1'b0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rsp_only_in_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> state_q == ST_RSP) else $error("response outside rsp state");
  a_unused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.cell_used |-> rsp_o.cell_glyph == '0)
    else $error("unused cell with glyph");
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q <= 15'(prpz_pkg::AngleWrap) || $stable(angle_q))
    else $error("angle out of range");
`endif
endmodule
`default_nettype wire

[rtl/prpz_ram.sv]
// prpz_ram: generic single port write, single port read ram, registered read
// no dependencies
`default_nettype none
module prpz_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

[rtl/prpz_xform.sv]
// prpz_xform: rotate, perspective and project one point, four register stages
// depends on prpz_pkg
`default_nettype none
module prpz_xform #(
  parameter int unsigned ScreenWidth  = 80,
  parameter int unsigned ScreenHeight = 24,
  parameter int unsigned CellW        = 11
) (
  input  wire                       clk_i,
  input  wire                       start_i,
  input  wire prpz_pkg::req_t       req_i,
  input  wire [14:0]                angle_i,
  output prpz_pkg::proj_t           proj_o,
  output logic [CellW-1:0]          cell_o
);
  // stage 1: phase and sin/cos
  logic [29:0] phase_full;
  logic [14:0] phase;
  logic signed [15:0] sin_q, cos_q;
  logic signed [15:0] x1_q, y1_q, z1_q;
  logic [31:0] g1_q;
  assign phase_full = 30'(angle_i) * 30'(prpz_pkg::PhaseMul);
  assign phase = phase_full[28:14];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sin_q <= prpz_pkg::sine_q14(phase);
      cos_q <= prpz_pkg::sine_q14(phase + 15'h4000);
      x1_q <= req_i.point_x;
      y1_q <= req_i.point_y;
      z1_q <= req_i.point_z;
      g1_q <= req_i.glyph_in;
    end
  end

  // stage 2: four products
  logic signed [31:0] xc_q, zs_q, zc_q, xs_q;
  always_ff @(posedge clk_i) begin
    xc_q <= x1_q * cos_q;
    zs_q <= z1_q * sin_q;
    zc_q <= z1_q * cos_q;
    xs_q <= x1_q * sin_q;
  end

  // stage 3: round, saturate, perspective product
  logic signed [33:0] rxs, rzs;
  logic signed [19:0] rxr, rzr;
  logic signed [15:0] rx, rz;
  logic signed [15:0] rx3_q, rz3_q, y3_q;
  logic signed [31:0] pz_q;
  logic [31:0] g3_q;
  assign rxs = 34'(xc_q) + 34'(zs_q) + 34'sd8192;
  assign rzs = 34'(zc_q) - 34'(xs_q) + 34'sd8192;
  assign rxr = rxs[33:14];
  assign rzr = rzs[33:14];
  assign rx = (rxr > 20'sd32767) ? 16'sd32767 :
              (rxr < -20'sd32768) ? -16'sd32768 : rxr[15:0];
  assign rz = (rzr > 20'sd32767) ? 16'sd32767 :
              (rzr < -20'sd32768) ? -16'sd32768 : rzr[15:0];
  always_ff @(posedge clk_i) begin
    rx3_q <= rx;
    rz3_q <= rz;
    y3_q  <= y1_q;
    g3_q  <= g1_q;
    pz_q  <= 32'(rz) * 32'sd3277 + 32'sd32768;
  end

  // stage 4: scale by perspective
  logic signed [15:0] p;
  logic signed [31:0] sxp_q, syp_q;
  logic signed [15:0] rz4_q;
  logic [31:0] g4_q;
  assign p = 16'sd256 + 16'(pz_q >>> 16);
  always_ff @(posedge clk_i) begin
    sxp_q <= rx3_q * p;
    syp_q <= y3_q * p;
    rz4_q <= rz3_q;
    g4_q  <= g3_q;
  end

  // truncate toward zero and clip to the inner cells
  logic signed [31:0] tx, ty, sx, sy;
  always_comb begin
    tx = (sxp_q < 0) ? -((-sxp_q) >>> 13) : (sxp_q >>> 13);
    ty = (syp_q < 0) ? -((-syp_q) >>> 14) : (syp_q >>> 14);
    sx = 32'(ScreenWidth / 2) + tx;
    sy = 32'(ScreenHeight / 2) - ty;
    proj_o.hit = (sx > 0) && (sx < 32'(ScreenWidth - 1)) &&
                 (sy > 1) && (sy < 32'(ScreenHeight - 1));
    proj_o.depth = rz4_q;
    proj_o.glyph = g4_q;
    cell_o = CellW'(sy * 32'(ScreenWidth) + sx);
  end
endmodule
`default_nettype wire
